// File: rtl/lke_pkg.sv
// shared types, constants and key tables of the layered keypad encoder
`default_nettype none

package lke_pkg;

    // field widths
    localparam int COL_W  = 3;
    localparam int ROW_W  = 3;
    localparam int BYTE_W = 8;
    localparam int CNT_W  = 3;
    localparam int CC_W   = 4;
    localparam int POS_W  = 5;

    // grid size
    localparam int GRID_COLS = 5;
    localparam int GRID_ROWS = 6;

    // highlight color classes
    localparam logic [CC_W-1:0] CC_PRIMARY = 4'd0;
    localparam logic [CC_W-1:0] CC_SHIFT   = 4'd1;
    localparam logic [CC_W-1:0] CC_META    = 4'd2;
    localparam logic [CC_W-1:0] CC_NUM     = 4'd3;
    localparam logic [CC_W-1:0] CC_SNUM    = 4'd4;
    localparam logic [CC_W-1:0] CC_GER     = 4'd5;
    localparam logic [CC_W-1:0] CC_FK      = 4'd6;
    localparam logic [CC_W-1:0] CC_HOLD    = 4'd7;
    localparam logic [CC_W-1:0] CC_TOGGLE  = 4'd8;

    // special key positions, row * 5 + column
    localparam logic [POS_W-1:0] KEY_R4C0 = 5'd20;
    localparam logic [POS_W-1:0] KEY_R4C1 = 5'd21;
    localparam logic [POS_W-1:0] KEY_R4C2 = 5'd22;
    localparam logic [POS_W-1:0] KEY_R5C0 = 5'd25;
    localparam logic [POS_W-1:0] KEY_R5C1 = 5'd26;
    localparam logic [POS_W-1:0] KEY_R5C2 = 5'd27;

    // ctrl offsets for the primary and shift layers
    localparam logic [BYTE_W-1:0] CTRL_PLAIN_OFS = 8'd96;
    localparam logic [BYTE_W-1:0] CTRL_UPPER_OFS = 8'd64;

    typedef struct packed {
        logic [COL_W-1:0] column;
        logic [ROW_W-1:0] row;
        logic             commit;
    } t_touch;

    typedef struct packed {
        logic [BYTE_W-1:0] byte0;
        logic [BYTE_W-1:0] byte1;
        logic [BYTE_W-1:0] byte2;
        logic [BYTE_W-1:0] byte3;
        logic [CNT_W-1:0]  byte_count;
        logic [CC_W-1:0]   color_class;
    } t_code;

    typedef struct packed {
        logic shift_on;
        logic number_layer;
        logic meta_layer;
        logic hold_lock;
        logic german_layer;
        logic function_layer;
        logic ctrl_mod;
        logic alt_mod;
        logic super_mod;
    } t_modes;

    // primary layer, lower case letters
    function automatic logic [7:0] f_plain(input logic [POS_W-1:0] pos);
        logic [7:0] b;
        case (pos)
            5'd0:  b = 8'h08;
            5'd1:  b = 8'h6D;
            5'd2:  b = 8'h6B;
            5'd3:  b = 8'h6C;
            5'd4:  b = 8'h70;
            5'd5:  b = 8'h76;
            5'd6:  b = 8'h6E;
            5'd7:  b = 8'h6A;
            5'd8:  b = 8'h69;
            5'd9:  b = 8'h6F;
            5'd10: b = 8'h63;
            5'd11: b = 8'h62;
            5'd12: b = 8'h68;
            5'd13: b = 8'h75;
            5'd14: b = 8'h7A;
            5'd15: b = 8'h78;
            5'd16: b = 8'h73;
            5'd17: b = 8'h67;
            5'd18: b = 8'h72;
            5'd19: b = 8'h74;
            5'd21: b = 8'h79;
            5'd22: b = 8'h66;
            5'd23: b = 8'h65;
            5'd24: b = 8'h77;
            5'd27: b = 8'h64;
            5'd28: b = 8'h61;
            5'd29: b = 8'h71;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // shift layer: upper case of the primary letters, no backspace
    function automatic logic [7:0] f_upper(input logic [POS_W-1:0] pos);
        logic [7:0] b;
        b = (pos == 5'd0) ? 8'h00 : (f_plain(pos) & 8'hDF);
        return b;
    endfunction

    // number layer
    function automatic logic [7:0] f_digits(input logic [POS_W-1:0] pos);
        logic [7:0] b;
        case (pos)
            5'd0:  b = 8'h5F;
            5'd1:  b = 8'h2D;
            5'd2:  b = 8'h2B;
            5'd3:  b = 8'h2F;
            5'd4:  b = 8'h2A;
            5'd5:  b = 8'h2E;
            5'd6:  b = 8'h3A;
            5'd7:  b = 8'h5C;
            5'd8:  b = 8'h30;
            5'd9:  b = 8'h35;
            5'd10: b = 8'h2C;
            5'd11: b = 8'h3B;
            5'd12: b = 8'h3F;
            5'd13: b = 8'h39;
            5'd14: b = 8'h34;
            5'd15: b = 8'h3C;
            5'd16: b = 8'h3E;
            5'd17: b = 8'h7C;
            5'd18: b = 8'h38;
            5'd19: b = 8'h33;
            5'd21: b = 8'h23;
            5'd22: b = 8'h27;
            5'd23: b = 8'h37;
            5'd24: b = 8'h32;
            5'd25: b = 8'h7E;
            5'd27: b = 8'h40;
            5'd28: b = 8'h36;
            5'd29: b = 8'h31;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // shifted number layer, first byte in the upper half
    function automatic logic [15:0] f_symbols(input logic [POS_W-1:0] pos);
        logic [15:0] b;
        case (pos)
            5'd8:  b = 16'h3D00;
            5'd9:  b = 16'h2500;
            5'd13: b = 16'h2900;
            5'd14: b = 16'h2400;
            5'd18: b = 16'h2800;
            5'd19: b = 16'hC2A7;
            5'd23: b = 16'h2F00;
            5'd24: b = 16'h2200;
            5'd28: b = 16'h2600;
            5'd29: b = 16'h2100;
            default: b = 16'h0000;
        endcase
        return b;
    endfunction

    // meta layer: control characters and escape sequences
    function automatic logic [31:0] f_control(input logic [POS_W-1:0] pos);
        logic [31:0] b;
        case (pos)
            5'd0:  b = 32'h0A000000;
            5'd1:  b = 32'h1B5B347E;
            5'd2:  b = 32'h1B5B4300;
            5'd3:  b = 32'h1B5B357E;
            5'd4:  b = 32'h1B5B367E;
            5'd5:  b = 32'h1B5B337E;
            5'd6:  b = 32'h1B5B327E;
            5'd7:  b = 32'h1B5B4200;
            5'd8:  b = 32'h1B5B4100;
            5'd10: b = 32'h20000000;
            5'd11: b = 32'h1B5B317E;
            5'd12: b = 32'h1B5B4400;
            5'd15: b = 32'h20000000;
            5'd28: b = 32'h09000000;
            5'd29: b = 32'h1B000000;
            default: b = 32'h00000000;
        endcase
        return b;
    endfunction

    // german layer, utf-8 sequences
    function automatic logic [23:0] f_german(input logic [POS_W-1:0] pos);
        logic [23:0] b;
        case (pos)
            5'd2:  b = 24'h600000;
            5'd7:  b = 24'hC2B400;
            5'd12: b = 24'hC2B000;
            5'd14: b = 24'hC39F00;
            5'd17: b = 24'h5E0000;
            5'd18: b = 24'hC39C00;
            5'd19: b = 24'hC3BC00;
            5'd22: b = 24'hC2B500;
            5'd23: b = 24'hC39600;
            5'd24: b = 24'hC3B600;
            5'd27: b = 24'hE282AC;
            5'd28: b = 24'hC38400;
            5'd29: b = 24'hC3A400;
            default: b = 24'h000000;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// File: rtl/lke_if.sv
// request channel interfaces of the layered keypad encoder
`default_nettype none

interface lke_touch_if;
    import lke_pkg::*;

    logic             valid;
    logic             ready;
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row;
    logic             commit;

    modport source (output valid, output column, output row, output commit, input ready);
    modport sink   (input valid, input column, input row, input commit, output ready);
endinterface

interface lke_code_if;
    import lke_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] byte0;
    logic [BYTE_W-1:0] byte1;
    logic [BYTE_W-1:0] byte2;
    logic [BYTE_W-1:0] byte3;
    logic [CNT_W-1:0]  byte_count;
    logic [CC_W-1:0]   color_class;

    modport source (output valid, output byte0, output byte1, output byte2, output byte3,
                    output byte_count, output color_class, input ready);
    modport sink   (input valid, input byte0, input byte1, input byte2, input byte3,
                    input byte_count, input color_class, output ready);
endinterface

`default_nettype wire

// File: rtl/lke_decode.sv
// combinational key decode: layer lookup, ctrl arithmetic and mode flag update
`default_nettype none

module lke_decode (
    input  lke_pkg::t_touch i_touch,
    input  lke_pkg::t_modes i_modes,
    output lke_pkg::t_code  o_code,
    output lke_pkg::t_modes o_modes
);
    import lke_pkg::*;

    logic              w_on_grid;
    logic              w_act;
    logic [POS_W-1:0]  w_pos;
    logic [31:0]       w_bytes;
    logic [CC_W-1:0]   w_cc;
    logic              w_clr_layers;
    logic              w_clr_mods;
    logic [BYTE_W-1:0] w_b0;
    t_modes            n_modes;

    // grid position, row * 5 + column
    assign w_on_grid = (i_touch.column < COL_W'(GRID_COLS)) && (i_touch.row < ROW_W'(GRID_ROWS));
    assign w_act     = i_touch.commit;
    assign w_pos     = {i_touch.row, 2'b00} + POS_W'(i_touch.row) + POS_W'(i_touch.column);

    // layer selection and flag toggles
    always_comb begin
        w_bytes      = 32'h0;
        w_cc         = CC_PRIMARY;
        w_clr_layers = 1'b1;
        w_clr_mods   = 1'b1;
        w_b0         = 8'h00;
        n_modes      = i_modes;
        if (w_on_grid) begin
            if (i_modes.meta_layer) begin
                if (i_modes.german_layer) begin
                    if (w_pos == KEY_R4C1) begin
                        w_cc = CC_HOLD;
                        if (w_act) n_modes.hold_lock = !i_modes.hold_lock;
                    end else begin
                        w_cc = CC_GER;
                        if (w_act) w_bytes = {f_german(w_pos), 8'h00};
                    end
                end else if (i_modes.function_layer) begin
                    w_cc = CC_FK;
                end else begin
                    case (w_pos)
                        KEY_R4C0: begin
                            w_cc = CC_TOGGLE;
                            if (w_act) begin
                                n_modes.alt_mod = !i_modes.alt_mod;
                                w_clr_mods      = 1'b0;
                            end
                        end
                        KEY_R4C1: begin
                            w_cc = CC_GER;
                            if (w_act) begin
                                n_modes.german_layer = 1'b1;
                                n_modes.hold_lock    = 1'b0;
                                w_clr_layers         = 1'b0;
                            end
                        end
                        KEY_R4C2: begin
                            w_cc = CC_FK;
                            if (w_act) begin
                                n_modes.function_layer = 1'b1;
                                n_modes.hold_lock      = 1'b0;
                                w_clr_layers           = 1'b0;
                            end
                        end
                        KEY_R5C0: begin
                            w_cc = CC_HOLD;
                            if (w_act) n_modes.hold_lock = !i_modes.hold_lock;
                        end
                        KEY_R5C1: begin
                            w_cc = CC_TOGGLE;
                            if (w_act) begin
                                n_modes.ctrl_mod = !i_modes.ctrl_mod;
                                w_clr_mods       = 1'b0;
                            end
                        end
                        KEY_R5C2: begin
                            w_cc = CC_TOGGLE;
                            if (w_act) begin
                                n_modes.super_mod = !i_modes.super_mod;
                                w_clr_mods        = 1'b0;
                            end
                        end
                        default: begin
                            w_cc = CC_META;
                            if (w_act) w_bytes = f_control(w_pos);
                        end
                    endcase
                end
            end else if (i_modes.number_layer) begin
                if (i_modes.shift_on) begin
                    if (w_pos == KEY_R5C1) begin
                        w_cc = CC_HOLD;
                        if (w_act) n_modes.hold_lock = !i_modes.hold_lock;
                    end else begin
                        w_cc = CC_SNUM;
                        if (w_act) w_bytes = {f_symbols(w_pos), 16'h0000};
                    end
                end else begin
                    if (w_pos == KEY_R4C0) begin
                        w_cc = CC_HOLD;
                        if (w_act) n_modes.hold_lock = !i_modes.hold_lock;
                    end else if (w_pos == KEY_R5C1) begin
                        w_cc = CC_SNUM;
                        if (w_act) begin
                            n_modes.shift_on  = 1'b1;
                            n_modes.hold_lock = 1'b0;
                            w_clr_layers      = 1'b0;
                        end
                    end else begin
                        w_cc = CC_NUM;
                        if (w_act) w_bytes = {f_digits(w_pos), 24'h000000};
                    end
                end
            end else if (i_modes.shift_on) begin
                if (w_pos == KEY_R5C1) begin
                    w_cc = CC_HOLD;
                    if (w_act) n_modes.hold_lock = !i_modes.hold_lock;
                end else begin
                    w_cc = CC_SHIFT;
                    if (w_act) begin
                        w_b0 = f_upper(w_pos);
                        if (i_modes.ctrl_mod) w_b0 = w_b0 - CTRL_UPPER_OFS;
                        w_bytes = {w_b0, 24'h000000};
                    end
                end
            end else begin
                if (w_pos == KEY_R4C0) begin
                    w_cc = CC_NUM;
                    if (w_act) begin
                        n_modes.number_layer = 1'b1;
                        w_clr_layers         = 1'b0;
                    end
                end else if (w_pos == KEY_R5C0) begin
                    w_cc = CC_META;
                    if (w_act) begin
                        n_modes.meta_layer = 1'b1;
                        w_clr_layers       = 1'b0;
                    end
                end else if (w_pos == KEY_R5C1) begin
                    w_cc = CC_SHIFT;
                    if (w_act) begin
                        n_modes.shift_on = 1'b1;
                        w_clr_layers     = 1'b0;
                    end
                end else begin
                    w_cc = CC_PRIMARY;
                    if (w_act) begin
                        w_b0 = f_plain(w_pos);
                        if (i_modes.ctrl_mod) w_b0 = w_b0 - CTRL_PLAIN_OFS;
                        w_bytes = {w_b0, 24'h000000};
                    end
                end
            end

            // layers drop after a committed key unless switched or held; modifiers are one-shot
            if (w_act) begin
                if (w_clr_layers && !n_modes.hold_lock) begin
                    n_modes.meta_layer     = 1'b0;
                    n_modes.number_layer   = 1'b0;
                    n_modes.shift_on       = 1'b0;
                    n_modes.german_layer   = 1'b0;
                    n_modes.function_layer = 1'b0;
                end
                if (w_clr_mods) begin
                    n_modes.ctrl_mod  = 1'b0;
                    n_modes.alt_mod   = 1'b0;
                    n_modes.super_mod = 1'b0;
                end
            end
        end
    end

    // result packing, count up to the first zero byte
    always_comb begin
        o_code.byte0       = w_bytes[31:24];
        o_code.byte1       = w_bytes[23:16];
        o_code.byte2       = w_bytes[15:8];
        o_code.byte3       = w_bytes[7:0];
        o_code.color_class = w_cc;
        if (w_bytes[31:24] == 8'h00)      o_code.byte_count = 3'd0;
        else if (w_bytes[23:16] == 8'h00) o_code.byte_count = 3'd1;
        else if (w_bytes[15:8] == 8'h00)  o_code.byte_count = 3'd2;
        else if (w_bytes[7:0] == 8'h00)   o_code.byte_count = 3'd3;
        else                              o_code.byte_count = 3'd4;
    end

    assign o_modes = n_modes;

endmodule

`default_nettype wire

// File: rtl/layered_keypad_encoder.sv
// top level of the layered keypad encoder: input register, decode, result register
//
// Usage: i_touch carries one touch per request (column, row, commit); o_code
// returns one result per touch: up to four bytes, their count and a color class.
// A commit of 0 is a press preview: only the color class is reported, bytes are
// zero and the mode flags stay. A commit of 1 emits the bytes and updates flags.
// Touches off the 5 by 6 grid give an all-zero result and change nothing.
// The input register loads at request acceptance; one pass of table lookup and
// flag update then fills the result register once that is free or drained.
// Throughput: one request per cycle while the receiver does not stall, set by
// the single decode pass that also writes the mode flags, so each touch sees
// the flags of the one before it.
// Reset (synchronous, active low) clears all nine mode flags and both valid
// bits. When the receiver stalls, the result register holds and the input
// register still takes one more request; after that i_touch.ready drops until
// the result is taken.
`default_nettype none

module layered_keypad_encoder (
    input wire     i_clk,
    input wire     i_rst_n,
    lke_touch_if.sink  i_touch,
    lke_code_if.source o_code
);
    import lke_pkg::*;

    logic   r_in_v;
    t_touch r_in;
    logic   r_out_v;
    t_code  r_out;
    t_modes r_modes;
    t_code  n_code;
    t_modes n_modes;
    logic   w_adv;
    logic   w_fire;
    logic   w_take;

    // handshake: the pipeline moves when the result register is free or drained
    assign w_adv         = !r_out_v || o_code.ready;
    assign w_fire        = r_in_v && w_adv;
    assign i_touch.ready = !r_in_v || w_adv;
    assign w_take        = i_touch.valid && i_touch.ready;

    lke_decode u_decode (
        .i_touch (r_in),
        .i_modes (r_modes),
        .o_code  (n_code),
        .o_modes (n_modes)
    );

    // control state and mode flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v  <= 1'b0;
            r_out_v <= 1'b0;
            r_modes <= '0;
        end else begin
            r_in_v <= w_take || (r_in_v && !w_adv);
            if (w_adv) r_out_v <= r_in_v;
            if (w_fire) r_modes <= n_modes;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in.column <= i_touch.column;
            r_in.row    <= i_touch.row;
            r_in.commit <= i_touch.commit;
        end
        if (w_fire) r_out <= n_code;
    end

    // result channel
    assign o_code.valid       = r_out_v;
    assign o_code.byte0       = r_out.byte0;
    assign o_code.byte1       = r_out.byte1;
    assign o_code.byte2       = r_out.byte2;
    assign o_code.byte3       = r_out.byte3;
    assign o_code.byte_count  = r_out.byte_count;
    assign o_code.color_class = r_out.color_class;

`ifndef NO_ASSERTIONS
    // flags change only when a committed touch passes through decode
    a_modes_quiet: assert property (@(posedge i_clk)
        (i_rst_n && !(w_fire && r_in.commit)) |=> $stable(r_modes))
        else $error("mode flags changed without a committed touch");

    // german and function-key layers live only under the meta layer
    a_sub_layer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_modes.german_layer || r_modes.function_layer) |-> r_modes.meta_layer)
        else $error("sub layer set without meta layer");

    // german and function-key layers never both on
    a_sub_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_modes.german_layer && r_modes.function_layer))
        else $error("german and function-key layers both set");

    // hold and toggle keys emit no bytes
    a_toggle_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_code.valid && (o_code.color_class == CC_HOLD || o_code.color_class == CC_TOGGLE))
        |-> (o_code.byte_count == 3'd0))
        else $error("hold or toggle key produced bytes");

    // a result is only loaded from a held request
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_in_v && w_adv) |=> !r_out_v)
        else $error("result valid without a request");
`endif

endmodule

`default_nettype wire

// File: dv/tb_layered_keypad_encoder.sv
// self-checking testbench of the layered keypad encoder: directed steps, then random touches
`timescale 1ns / 1ps

module tb_layered_keypad_encoder;
    import lke_pkg::*;

    // one directed step: touch, and the code when it is typed in by hand
    typedef struct packed {
        logic             typed;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             commit;
        t_code            code;
    } t_step_row;

    localparam int N_DIRECTED = 25;
    localparam int N_ITEMS    = 700;
    localparam int CALM_FROM  = 620;

    // dense one-byte layers, grid position 0 in the top byte
    localparam logic [30*8-1:0] PLAIN_KEYS =
        {8'h08, "mklpvnjiocbhuzxsgrt", 8'h00, "yfew", 16'h0000, "daq"};
    localparam logic [30*8-1:0] UPPER_KEYS =
        {8'h00, "MKLPVNJIOCBHUZXSGRT", 8'h00, "YFEW", 16'h0000, "DAQ"};
    localparam logic [30*8-1:0] DIGIT_KEYS =
        {"_-+/*.:\\05,;?94<>|83", 8'h00, "#'72~", 8'h00, "@61"};

    logic clk;
    logic rst_n;

    lke_touch_if touch_if ();
    lke_code_if  code_if ();

    layered_keypad_encoder i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_touch (touch_if),
        .o_code  (code_if)
    );

    t_modes    modes;
    t_code     expected_codes [$];
    t_step_row directed_steps [N_DIRECTED];
    int        mismatches;
    int        touches_on_grid;
    bit        calm;

    // clock
    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // byte of a dense layer at a grid position
    function automatic logic [7:0] grid_byte(input logic [30*8-1:0] keys,
                                             input logic [POS_W-1:0] pos);
        return keys[(29 - pos) * 8 +: 8];
    endfunction

    // expected code of one touch, updates the mode flags on a release
    function automatic t_code encode_touch(input t_touch t);
        t_code            c;
        logic [31:0]      seq;
        logic [CC_W-1:0]  cc;
        logic [POS_W-1:0] pos;
        logic             act;
        logic             keep_layers;
        logic             keep_mods;
        int               n;
        seq         = '0;
        cc          = CC_PRIMARY;
        act         = t.commit;
        keep_layers = 1'b0;
        keep_mods   = 1'b0;
        if (t.column < GRID_COLS && t.row < GRID_ROWS) begin
            pos = POS_W'(t.row * GRID_COLS + t.column);
            if (modes.meta_layer) begin
                if (modes.german_layer) begin
                    if (pos == KEY_R4C1) begin
                        cc = CC_HOLD;
                        if (act) modes.hold_lock = !modes.hold_lock;
                    end else begin
                        cc = CC_GER;
                        if (act) begin
                            case (pos)
                                5'd2:    seq = 32'h60000000;
                                5'd7:    seq = 32'hC2B40000;
                                5'd12:   seq = 32'hC2B00000;
                                5'd14:   seq = 32'hC39F0000;
                                5'd17:   seq = 32'h5E000000;
                                5'd18:   seq = 32'hC39C0000;
                                5'd19:   seq = 32'hC3BC0000;
                                5'd22:   seq = 32'hC2B50000;
                                5'd23:   seq = 32'hC3960000;
                                5'd24:   seq = 32'hC3B60000;
                                5'd27:   seq = 32'hE282AC00;
                                5'd28:   seq = 32'hC3840000;
                                5'd29:   seq = 32'hC3A40000;
                                default: seq = 32'h00000000;
                            endcase
                        end
                    end
                end else if (modes.function_layer) begin
                    cc = CC_FK;
                end else begin
                    case (pos)
                        KEY_R4C0: begin
                            cc = CC_TOGGLE;
                            if (act) begin
                                modes.alt_mod = !modes.alt_mod;
                                keep_mods     = 1'b1;
                            end
                        end
                        KEY_R4C1: begin
                            cc = CC_GER;
                            if (act) begin
                                modes.german_layer = 1'b1;
                                modes.hold_lock    = 1'b0;
                                keep_layers        = 1'b1;
                            end
                        end
                        KEY_R4C2: begin
                            cc = CC_FK;
                            if (act) begin
                                modes.function_layer = 1'b1;
                                modes.hold_lock      = 1'b0;
                                keep_layers          = 1'b1;
                            end
                        end
                        KEY_R5C0: begin
                            cc = CC_HOLD;
                            if (act) modes.hold_lock = !modes.hold_lock;
                        end
                        KEY_R5C1: begin
                            cc = CC_TOGGLE;
                            if (act) begin
                                modes.ctrl_mod = !modes.ctrl_mod;
                                keep_mods      = 1'b1;
                            end
                        end
                        KEY_R5C2: begin
                            cc = CC_TOGGLE;
                            if (act) begin
                                modes.super_mod = !modes.super_mod;
                                keep_mods       = 1'b1;
                            end
                        end
                        default: begin
                            cc = CC_META;
                            if (act) begin
                                case (pos)
                                    5'd0:    seq = 32'h0A000000;
                                    5'd1:    seq = 32'h1B5B347E;
                                    5'd2:    seq = 32'h1B5B4300;
                                    5'd3:    seq = 32'h1B5B357E;
                                    5'd4:    seq = 32'h1B5B367E;
                                    5'd5:    seq = 32'h1B5B337E;
                                    5'd6:    seq = 32'h1B5B327E;
                                    5'd7:    seq = 32'h1B5B4200;
                                    5'd8:    seq = 32'h1B5B4100;
                                    5'd10:   seq = 32'h20000000;
                                    5'd11:   seq = 32'h1B5B317E;
                                    5'd12:   seq = 32'h1B5B4400;
                                    5'd15:   seq = 32'h20000000;
                                    5'd28:   seq = 32'h09000000;
                                    5'd29:   seq = 32'h1B000000;
                                    default: seq = 32'h00000000;
                                endcase
                            end
                        end
                    endcase
                end
            end else if (modes.number_layer) begin
                if (modes.shift_on) begin
                    if (pos == KEY_R5C1) begin
                        cc = CC_HOLD;
                        if (act) modes.hold_lock = !modes.hold_lock;
                    end else begin
                        cc = CC_SNUM;
                        if (act) begin
                            case (pos)
                                5'd8:    seq = 32'h3D000000;
                                5'd9:    seq = 32'h25000000;
                                5'd13:   seq = 32'h29000000;
                                5'd14:   seq = 32'h24000000;
                                5'd18:   seq = 32'h28000000;
                                5'd19:   seq = 32'hC2A70000;
                                5'd23:   seq = 32'h2F000000;
                                5'd24:   seq = 32'h22000000;
                                5'd28:   seq = 32'h26000000;
                                5'd29:   seq = 32'h21000000;
                                default: seq = 32'h00000000;
                            endcase
                        end
                    end
                end else if (pos == KEY_R4C0) begin
                    cc = CC_HOLD;
                    if (act) modes.hold_lock = !modes.hold_lock;
                end else if (pos == KEY_R5C1) begin
                    cc = CC_SNUM;
                    if (act) begin
                        modes.shift_on  = 1'b1;
                        modes.hold_lock = 1'b0;
                        keep_layers     = 1'b1;
                    end
                end else begin
                    cc = CC_NUM;
                    if (act) seq[31:24] = grid_byte(DIGIT_KEYS, pos);
                end
            end else if (modes.shift_on) begin
                if (pos == KEY_R5C1) begin
                    cc = CC_HOLD;
                    if (act) modes.hold_lock = !modes.hold_lock;
                end else begin
                    cc = CC_SHIFT;
                    if (act) begin
                        seq[31:24] = grid_byte(UPPER_KEYS, pos);
                        if (modes.ctrl_mod) seq[31:24] = seq[31:24] - CTRL_UPPER_OFS;
                    end
                end
            end else if (pos == KEY_R4C0) begin
                cc = CC_NUM;
                if (act) begin
                    modes.number_layer = 1'b1;
                    keep_layers        = 1'b1;
                end
            end else if (pos == KEY_R5C0) begin
                cc = CC_META;
                if (act) begin
                    modes.meta_layer = 1'b1;
                    keep_layers      = 1'b1;
                end
            end else if (pos == KEY_R5C1) begin
                cc = CC_SHIFT;
                if (act) begin
                    modes.shift_on = 1'b1;
                    keep_layers    = 1'b1;
                end
            end else begin
                cc = CC_PRIMARY;
                if (act) begin
                    seq[31:24] = grid_byte(PLAIN_KEYS, pos);
                    if (modes.ctrl_mod) seq[31:24] = seq[31:24] - CTRL_PLAIN_OFS;
                end
            end

            // layers drop after a release unless switched or held, modifiers unless toggled
            if (act) begin
                if (!keep_layers && !modes.hold_lock) begin
                    modes.meta_layer     = 1'b0;
                    modes.number_layer   = 1'b0;
                    modes.shift_on       = 1'b0;
                    modes.german_layer   = 1'b0;
                    modes.function_layer = 1'b0;
                end
                if (!keep_mods) begin
                    modes.ctrl_mod  = 1'b0;
                    modes.alt_mod   = 1'b0;
                    modes.super_mod = 1'b0;
                end
            end
        end

        // bytes up to the first zero
        n = 0;
        while (n < 4 && seq[31 - 8 * n -: 8] != 8'h00) n++;
        c.byte0       = seq[31:24];
        c.byte1       = seq[23:16];
        c.byte2       = seq[15:8];
        c.byte3       = seq[7:0];
        c.byte_count  = CNT_W'(n);
        c.color_class = cc;
        return c;
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch on %s: got 'h%0h, want 'h%0h", $realtime, what, got, want);
        mismatches++;
    endtask

    // drive one touch request, queue its expected code once accepted
    task automatic send_touch(input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row,
                              input logic commit, input logic typed, input t_code given);
        t_touch t;
        t_code  predicted;
        t.column = col;
        t.row    = row;
        t.commit = commit;
        if (!calm && $urandom_range(0, 5) == 0) begin
            touch_if.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        touch_if.valid  <= 1'b1;
        touch_if.column <= col;
        touch_if.row    <= row;
        touch_if.commit <= commit;
        @(posedge clk);
        while (!touch_if.ready) @(posedge clk);
        predicted = encode_touch(t);
        expected_codes.push_back(typed ? given : predicted);
        if (col < GRID_COLS && row < GRID_ROWS) touches_on_grid++;
        @(negedge clk);
    endtask

    // a key, sometimes with its press preview first
    task automatic tap(input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row);
        if ($urandom_range(0, 1) == 1) send_touch(col, row, 1'b0, 1'b0, '0);
        send_touch(col, row, 1'b1, 1'b0, '0);
    endtask

    task automatic tap_any();
        tap(COL_W'($urandom_range(0, GRID_COLS - 1)), ROW_W'($urandom_range(0, GRID_ROWS - 1)));
    endtask

    task automatic wait_drained();
        while (expected_codes.size() != 0) @(negedge clk);
    endtask

    // result receiver: random back-pressure bursts, none near the end
    initial begin
        code_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 7) == 0) begin
                code_if.ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(negedge clk);
            end
            code_if.ready <= 1'b1;
        end
    end

    // compare every accepted code with the oldest expectation
    always @(posedge clk) begin : check_codes
        t_code want;
        if (rst_n && code_if.valid && code_if.ready) begin
            if (expected_codes.size() == 0) begin
                flag_mismatch("unexpected result, byte0", code_if.byte0, 0);
            end else begin
                want = expected_codes.pop_front();
                if (code_if.byte0 !== want.byte0)
                    flag_mismatch("byte0", code_if.byte0, want.byte0);
                if (code_if.byte1 !== want.byte1)
                    flag_mismatch("byte1", code_if.byte1, want.byte1);
                if (code_if.byte2 !== want.byte2)
                    flag_mismatch("byte2", code_if.byte2, want.byte2);
                if (code_if.byte3 !== want.byte3)
                    flag_mismatch("byte3", code_if.byte3, want.byte3);
                if (code_if.byte_count !== want.byte_count)
                    flag_mismatch("byte_count", code_if.byte_count, want.byte_count);
                if (code_if.color_class !== want.color_class)
                    flag_mismatch("color_class", code_if.color_class, want.color_class);
            end
        end
    end

    // stimulus
    initial begin : stimulus
        bit drained_mid;
        int k;
        rst_n           = 1'b0;
        touch_if.valid  = 1'b0;
        touch_if.column = '0;
        touch_if.row    = '0;
        touch_if.commit = 1'b0;
        modes           = '0;
        mismatches      = 0;
        touches_on_grid = 0;
        calm            = 1'b0;
        drained_mid     = 1'b0;

        // directed steps: reset view, grid extremes, off-grid touches, every layer
        directed_steps = '{
            '{1'b1, 3'd0, 3'd0, 1'b0, '{8'h00, 8'h00, 8'h00, 8'h00, 3'd0, CC_PRIMARY}},
            '{1'b1, 3'd0, 3'd0, 1'b1, '{8'h08, 8'h00, 8'h00, 8'h00, 3'd1, CC_PRIMARY}},
            '{1'b1, 3'd4, 3'd5, 1'b1, '{8'h71, 8'h00, 8'h00, 8'h00, 3'd1, CC_PRIMARY}},
            '{1'b1, 3'd7, 3'd0, 1'b1, '{8'h00, 8'h00, 8'h00, 8'h00, 3'd0, CC_PRIMARY}},
            '{1'b1, 3'd0, 3'd7, 1'b1, '{8'h00, 8'h00, 8'h00, 8'h00, 3'd0, CC_PRIMARY}},
            '{1'b1, 3'd7, 3'd7, 1'b0, '{8'h00, 8'h00, 8'h00, 8'h00, 3'd0, CC_PRIMARY}},
            '{1'b1, 3'd1, 3'd5, 1'b1, '{8'h00, 8'h00, 8'h00, 8'h00, 3'd0, CC_SHIFT}},
            '{1'b0, 3'd0, 3'd1, 1'b1, '0},   // upper case letter
            '{1'b0, 3'd0, 3'd4, 1'b0, '0},   // preview of the number key
            '{1'b0, 3'd0, 3'd4, 1'b1, '0},   // number layer on
            '{1'b0, 3'd1, 3'd5, 1'b1, '0},   // shifted numbers on
            '{1'b0, 3'd4, 3'd3, 1'b1, '0},   // two-byte symbol
            '{1'b0, 3'd0, 3'd5, 1'b1, '0},   // meta on
            '{1'b0, 3'd1, 3'd5, 1'b1, '0},   // ctrl toggle
            '{1'b0, 3'd3, 3'd5, 1'b1, '0},   // ctrl letter
            '{1'b0, 3'd0, 3'd5, 1'b1, '0},
            '{1'b0, 3'd1, 3'd4, 1'b1, '0},   // german on
            '{1'b0, 3'd2, 3'd5, 1'b1, '0},   // three-byte sequence
            '{1'b0, 3'd0, 3'd5, 1'b1, '0},
            '{1'b0, 3'd2, 3'd4, 1'b1, '0},   // function-key layer on
            '{1'b0, 3'd4, 3'd5, 1'b1, '0},   // function key emits nothing
            '{1'b0, 3'd0, 3'd5, 1'b1, '0},
            '{1'b0, 3'd1, 3'd0, 1'b1, '0},   // four-byte escape sequence
            '{1'b0, 3'd0, 3'd5, 1'b1, '0},
            '{1'b0, 3'd0, 3'd5, 1'b1, '0}    // hold in meta
        };

        // reset
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            send_touch(directed_steps[i].col, directed_steps[i].row, directed_steps[i].commit,
                       directed_steps[i].typed, directed_steps[i].code);
        end
        touch_if.valid <= 1'b0;
        wait_drained();

        // random part: mostly layer sequences with random keys, some raw noise
        while (touches_on_grid < N_ITEMS) begin
            if (touches_on_grid >= CALM_FROM) calm = 1'b1;
            if (!drained_mid && touches_on_grid >= N_ITEMS / 2) begin
                drained_mid = 1'b1;
                touch_if.valid <= 1'b0;
                wait_drained();
            end
            case ($urandom_range(0, 9))
                0: tap_any();
                1: begin
                    tap(3'd1, 3'd5);
                    tap_any();
                end
                2: begin
                    tap(3'd0, 3'd4);
                    if ($urandom_range(0, 1) == 1) tap(3'd1, 3'd5);
                    tap_any();
                end
                3: begin
                    tap(3'd0, 3'd5);
                    tap_any();
                end
                4: begin
                    tap(3'd0, 3'd5);
                    tap(3'd1, 3'd4);
                    tap_any();
                end
                5: begin
                    tap(3'd0, 3'd5);
                    tap(3'd2, 3'd4);
                    tap_any();
                end
                6: begin
                    // meta special keys: modifiers, layer switches, hold
                    tap(3'd0, 3'd5);
                    tap(COL_W'($urandom_range(0, 2)), ROW_W'($urandom_range(4, 5)));
                    tap_any();
                end
                7: begin
                    // enter a layer, lock it, then a few keys
                    k = $urandom_range(0, 3);
                    case (k)
                        0: begin
                            tap(3'd0, 3'd5);
                            tap(3'd0, 3'd5);
                        end
                        1: begin
                            tap(3'd0, 3'd4);
                            tap(3'd0, 3'd4);
                        end
                        2: begin
                            tap(3'd1, 3'd5);
                            tap(3'd1, 3'd5);
                        end
                        default: begin
                            tap(3'd0, 3'd5);
                            tap(3'd1, 3'd4);
                            tap(3'd1, 3'd4);
                        end
                    endcase
                    repeat ($urandom_range(1, 4)) tap_any();
                end
                8: begin
                    send_touch(COL_W'($urandom_range(0, 7)), ROW_W'($urandom_range(0, 7)),
                               1'($urandom_range(0, 1)), 1'b0, '0);
                end
                default: begin
                    // ctrl, then a plain or shifted key
                    tap(3'd0, 3'd5);
                    tap(3'd1, 3'd5);
                    if ($urandom_range(0, 1) == 1) tap(3'd1, 3'd5);
                    tap_any();
                end
            endcase
        end
        touch_if.valid <= 1'b0;

        // drain and let the pipeline settle
        while (expected_codes.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: filelist.f
rtl/lke_pkg.sv
rtl/lke_if.sv
rtl/lke_decode.sv
rtl/layered_keypad_encoder.sv
dv/tb_layered_keypad_encoder.sv
